[design/zbr_pkg.sv]
// Shared constants, codes and handshake types of the z-buffered triangle rasterizer.
// No dependencies; every other file of the block imports this package.
package zbr_pkg;

  localparam int MAX_WIDTH    = 512;
  localparam int MAX_HEIGHT   = 512;
  localparam int DEPTH_LEVELS = 255;

  localparam int XW      = $clog2(MAX_WIDTH);
  localparam int YW      = $clog2(MAX_HEIGHT);
  localparam int AW      = XW + YW;
  localparam int VW      = 24;
  localparam int CW      = 23;
  localparam int CFG_W   = 10;
  localparam int DEPTH_W = 8;
  localparam int WGT_W   = 15;
  localparam int KIND_W  = 2;

  localparam logic [CW-2:0] COORD_LIM = {(CW-1){1'b1}};
  localparam int DLIM = (DEPTH_LEVELS > 255) ? 255 : DEPTH_LEVELS;
  localparam int AREA_MIN = 65536;

  localparam int DIV_NW = 64;
  localparam int DIV_DW = 50;
  localparam int DIV_QW = 23;
  localparam int DIV_SW = DIV_DW + DIV_QW;

  localparam int MUL_W  = 24;
  localparam int PROD_W = 48;
  localparam int EDGE_W = 51;
  localparam int UA_W   = 49;

  localparam logic [KIND_W-1:0] K_LOADED   = 2'd0;
  localparam logic [KIND_W-1:0] K_WRITTEN  = 2'd1;
  localparam logic [KIND_W-1:0] K_REJECTED = 2'd2;
  localparam logic [KIND_W-1:0] K_DONE     = 2'd3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [1:0] SLOT_NONE = 2'd3;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [DIV_QW-1:0] quot;
  } div_rsp_t;

endpackage

[design/zbr_div.sv]
// Restoring divider, one quotient bit per cycle, with quotient overflow flag.
// Depends on zbr_pkg (widths, div_req_t, div_rsp_t).
module zbr_div (
  input  logic              clk,
  input  logic              rst_n,
  input  zbr_pkg::div_req_t req,
  output zbr_pkg::div_rsp_t rsp
);
  import zbr_pkg::*;

  localparam int CNT_W = $clog2(DIV_QW + 1);

  logic [DIV_SW-1:0] rem_r, rem_nxt, ds_r, ds_nxt;
  logic [DIV_QW-1:0] q_r, q_nxt;
  logic              ovf_r, ovf_nxt, run_r, run_nxt, done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIV_SW:0]   diff;

  always_comb begin
    rem_nxt  = rem_r;
    ds_nxt   = ds_r;
    q_nxt    = q_r;
    ovf_nxt  = ovf_r;
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    diff     = {1'b0, rem_r} - {1'b0, ds_r};
    if (req.start) begin
      rem_nxt = DIV_SW'(req.num);
      ds_nxt  = DIV_SW'({req.den, {(DIV_QW-1){1'b0}}});
      ovf_nxt = DIV_SW'(req.num) >= DIV_SW'({req.den, {DIV_QW{1'b0}}});
      q_nxt   = '0;
      cnt_nxt = CNT_W'(DIV_QW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!diff[DIV_SW]) rem_nxt = diff[DIV_SW-1:0];
      q_nxt   = {q_r[DIV_QW-2:0], ~diff[DIV_SW]};
      ds_nxt  = ds_r >> 1;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    ds_r  <= ds_nxt;
    q_r   <= q_nxt;
    ovf_r <= ovf_nxt;
  end

  assign rsp = '{done: done_r, ovf: ovf_r, quot: q_r};

endmodule

[design/zbr_depth_ram.sv]
// Depth store: one write and one registered read port, cleared by a sweep after reset.
// Depends on zbr_pkg (address and depth widths).
module zbr_depth_ram (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [zbr_pkg::AW-1:0]      wr_addr,
  input  logic [zbr_pkg::DEPTH_W-1:0] wr_data,
  input  logic [zbr_pkg::AW-1:0]      rd_addr,
  output logic [zbr_pkg::DEPTH_W-1:0] rd_data,
  output logic                        clearing
);
  import zbr_pkg::*;

  logic [DEPTH_W-1:0] mem [0:(1<<AW)-1];
  logic               clr_r, clr_nxt;
  logic [AW-1:0]      clr_cnt_r, clr_cnt_nxt;

  always_comb begin
    clr_nxt     = clr_r;
    clr_cnt_nxt = clr_cnt_r;
    if (clr_r) begin
      clr_cnt_nxt = clr_cnt_r + AW'(1);
      if (clr_cnt_r == {AW{1'b1}}) clr_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else begin
      clr_r     <= clr_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) mem[clr_cnt_r] <= '0;
    else if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  assign clearing = clr_r;

endmodule

[design/zbuffered_triangle_rasterizer_unit.sv]
// Top level of the z-buffered triangle rasterizer: command sequencer, edge math, depth test.
// Depends on zbr_pkg, zbr_div and zbr_depth_ram.
//
// One command at a time: start is taken while busy is low, and its single result beat
// appears on the out_ ports for one cycle with out_strobe; the receiver cannot stall, so
// every beat must be taken when shown. busy stays high through the beat cycle, so the next
// command is taken in the cycle after the beat at the earliest. After reset the depth store is
// cleared one entry a cycle (MAX_WIDTH*MAX_HEIGHT = 262144 entries) with busy held high; cfg
// writes are taken throughout. A vertex load runs three divisions by w before its beat, and
// skips them with w zero; a bad slot or a step with no active walk gets its beat straight from
// the idle state. A pixel step forms the edge terms and the area on the shared multiplier,
// then a weight division and a depth product per corner, rounding and the depth store update;
// a pixel outside the triangle or of a degenerate one gets its beat after the edge products.
module zbuffered_triangle_rasterizer_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_command,
  input  logic [1:0]                  in_vertex_slot,
  input  logic signed [23:0]          in_vert_x,
  input  logic signed [23:0]          in_vert_y,
  input  logic signed [23:0]          in_vert_z,
  input  logic signed [23:0]          in_vert_w,
  output logic                        out_strobe,
  output logic [zbr_pkg::KIND_W-1:0]  out_result_kind,
  output logic [zbr_pkg::XW-1:0]      out_pixel_x,
  output logic [zbr_pkg::YW-1:0]      out_pixel_y,
  output logic [zbr_pkg::DEPTH_W-1:0] out_frag_depth_out,
  output logic [zbr_pkg::WGT_W-1:0]   out_weight_a,
  output logic [zbr_pkg::WGT_W-1:0]   out_weight_b,
  output logic [zbr_pkg::WGT_W-1:0]   out_weight_c,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [zbr_pkg::CFG_W-1:0]   cfg_wdata
);
  import zbr_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_VDIV   = 4'd1;
  localparam logic [3:0] S_VWAIT  = 4'd2;
  localparam logic [3:0] S_VSTORE = 4'd3;
  localparam logic [3:0] S_SETUP  = 4'd4;
  localparam logic [3:0] S_PREP   = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_EDGE   = 4'd7;
  localparam logic [3:0] S_WDIV   = 4'd8;
  localparam logic [3:0] S_WWAIT  = 4'd9;
  localparam logic [3:0] S_DMUL   = 4'd10;
  localparam logic [3:0] S_DFIN   = 4'd11;
  localparam logic [3:0] S_DCMP   = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic [2:0] k_r, k_nxt;
  logic [2:0] km1;

  logic [CFG_W-1:0] fw_r, fw_nxt, fh_r, fh_nxt;

  logic [1:0]           slot_r, slot_nxt;
  logic signed [VW-1:0] vx_r, vx_nxt, vy_r, vy_nxt, vz_r, vz_nxt, vw_r, vw_nxt;

  logic signed [CW-1:0] px_r [0:2];
  logic signed [CW-1:0] py_r [0:2];
  logic signed [CW-1:0] pd_r [0:2];
  logic signed [CW-1:0] px_nxt [0:2];
  logic signed [CW-1:0] py_nxt [0:2];
  logic signed [CW-1:0] pd_nxt [0:2];
  logic signed [CW-1:0] t_r [0:2];
  logic signed [CW-1:0] t_nxt [0:2];
  logic [2:0]           usable_r, usable_nxt;

  logic [XW-1:0] bx0_r, bx0_nxt, bx1_r, bx1_nxt, cur_x_r, cur_x_nxt, x_r, x_nxt;
  logic [YW-1:0] by0_r, by0_nxt, by1_r, by1_nxt, cur_y_r, cur_y_nxt, y_r, y_nxt;
  logic          active_r, active_nxt;

  logic signed [MUL_W-1:0]  dbx_r, dbx_nxt, dby_r, dby_nxt, dcx_r, dcx_nxt, dcy_r, dcy_nxt;
  logic signed [MUL_W-1:0]  qx_r, qx_nxt, qy_r, qy_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt, sum_r, sum_nxt;
  logic signed [EDGE_W-1:0] nb_r, nb_nxt, nc_r, nc_nxt, area_r, area_nxt, na_r, na_nxt;
  logic [WGT_W-1:0]         wgt_r [0:2];
  logic [WGT_W-1:0]         wgt_nxt [0:2];
  logic [DEPTH_W-1:0]       f_r, f_nxt;

  logic                 o_strobe_r, o_strobe_nxt;
  logic [KIND_W-1:0]    o_kind_r, o_kind_nxt;
  logic [XW-1:0]        o_x_r, o_x_nxt;
  logic [YW-1:0]        o_y_r, o_y_nxt;
  logic [DEPTH_W-1:0]   o_d_r, o_d_nxt;
  logic [WGT_W-1:0]     o_wa_r, o_wa_nxt, o_wb_r, o_wb_nxt, o_wc_r, o_wc_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic               ram_we, ram_clearing;
  logic [DEPTH_W-1:0] ram_q;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;

  logic signed [VW-1:0] v_sel;
  logic [VW-1:0]        vmag, wmag;
  logic                 vsat;
  logic [CW-2:0]        vm;
  logic signed [CW-1:0] vres;

  logic signed [EDGE_W-1:0] n_sel, na_c, nmag_full, ua_full;
  logic [UA_W-1:0]          nmag, ua;
  logic                     in_tri, reject;

  logic signed [CW-1:0] mnx, mny, mxx, mxy;
  logic [CW-2:0]        mxxc, mxyc, limx, limy;
  logic [CW-10:0]       x0full, y0full;
  logic [XW:0]          dimx;
  logic [YW:0]          dimy;
  logic [XW-1:0]        sx1;
  logic [YW-1:0]        sy1;
  logic                 box_ok;

  logic signed [PROD_W-1:0] rnd;
  logic [PROD_W-23:0]       rnd_hi;

  zbr_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  zbr_depth_ram u_ram (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (ram_we),
    .wr_addr  ({y_r, x_r}),
    .wr_data  (f_r),
    .rd_addr  ({y_r, x_r}),
    .rd_data  (ram_q),
    .clearing (ram_clearing)
  );

  assign busy = (state_r != S_IDLE) || ram_clearing || o_strobe_r;
  assign km1  = k_r - 3'd1;

  // vertex division operands and rounded, saturated quotient
  always_comb begin
    case (k_r)
      3'd0:    v_sel = vx_r;
      3'd1:    v_sel = vy_r;
      default: v_sel = vz_r;
    endcase
    vmag = v_sel[VW-1] ? VW'(-v_sel) : VW'(v_sel);
    wmag = vw_r[VW-1] ? VW'(-vw_r) : VW'(vw_r);
    vsat = div_rsp.ovf || (div_rsp.quot > {1'b0, COORD_LIM});
    vm   = vsat ? COORD_LIM : div_rsp.quot[CW-2:0];
    vres = (v_sel[VW-1] ^ vw_r[VW-1]) ? -$signed({1'b0, vm}) : $signed({1'b0, vm});
  end

  // edge terms, weight division operands
  always_comb begin
    na_c   = area_r - nb_r - nc_r;
    if (area_r > 0) in_tri = (na_c >= 0) && (nb_r >= 0) && (nc_r >= 0);
    else            in_tri = (na_c <= 0) && (nb_r <= 0) && (nc_r <= 0);
    ua_full = (area_r < 0) ? -area_r : area_r;
    ua      = ua_full[UA_W-1:0];
    reject  = (ua_full < EDGE_W'(AREA_MIN)) || !in_tri;
    case (k_r)
      3'd0:    n_sel = na_r;
      3'd1:    n_sel = nb_r;
      default: n_sel = nc_r;
    endcase
    nmag_full = (n_sel < 0) ? -n_sel : n_sel;
    nmag      = nmag_full[UA_W-1:0];
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_MUL) begin
      case (k_r)
        3'd0:    begin mul_a = dcx_r; mul_b = qy_r;  end
        3'd1:    begin mul_a = qx_r;  mul_b = dcy_r; end
        3'd2:    begin mul_a = qx_r;  mul_b = dby_r; end
        3'd3:    begin mul_a = dbx_r; mul_b = qy_r;  end
        3'd4:    begin mul_a = dbx_r; mul_b = dcy_r; end
        default: begin mul_a = dcx_r; mul_b = dby_r; end
      endcase
    end else begin
      case (k_r)
        3'd0:    begin mul_a = $signed(MUL_W'(wgt_r[0])); mul_b = MUL_W'(pd_r[0]); end
        3'd1:    begin mul_a = $signed(MUL_W'(wgt_r[1])); mul_b = MUL_W'(pd_r[1]); end
        default: begin mul_a = $signed(MUL_W'(wgt_r[2])); mul_b = MUL_W'(pd_r[2]); end
      endcase
    end
    mul_p = mul_a * mul_b;
  end

  // bounding box of the three corners, clamped to the frame
  always_comb begin
    mnx = px_r[0];
    mny = py_r[0];
    if (px_r[1] < mnx) mnx = px_r[1];
    if (px_r[2] < mnx) mnx = px_r[2];
    if (py_r[1] < mny) mny = py_r[1];
    if (py_r[2] < mny) mny = py_r[2];
    if (mnx < 0) mnx = '0;
    if (mny < 0) mny = '0;
    mxx = '0;
    mxy = '0;
    for (int i = 0; i < 3; i++) begin
      if (px_r[i] > mxx) mxx = px_r[i];
      if (py_r[i] > mxy) mxy = py_r[i];
    end
    if (fw_r == '0) dimx = (XW+1)'(1);
    else if (int'(fw_r) > MAX_WIDTH) dimx = (XW+1)'(MAX_WIDTH);
    else dimx = (XW+1)'(fw_r);
    if (fh_r == '0) dimy = (YW+1)'(1);
    else if (int'(fh_r) > MAX_HEIGHT) dimy = (YW+1)'(MAX_HEIGHT);
    else dimy = (YW+1)'(fh_r);
    limx = (CW-1)'({XW'(dimx - (XW+1)'(1)), 8'b0});
    limy = (CW-1)'({YW'(dimy - (YW+1)'(1)), 8'b0});
    mxxc = (mxx[CW-2:0] > limx) ? limx : mxx[CW-2:0];
    mxyc = (mxy[CW-2:0] > limy) ? limy : mxy[CW-2:0];
    sx1  = mxxc[XW+7:8];
    sy1  = mxyc[YW+7:8];
    x0full = mnx[CW-2:8];
    y0full = mny[CW-2:8];
    box_ok = (&usable_r) && (x0full <= (CW-9)'(sx1)) && (y0full <= (CW-9)'(sy1));
  end

  // depth rounding and the upper bits for the clamp
  always_comb begin
    rnd    = sum_r + PROD_W'(1 << 21);
    rnd_hi = rnd[PROD_W-1:22];
  end

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    fw_nxt     = fw_r;
    fh_nxt     = fh_r;
    slot_nxt   = slot_r;
    vx_nxt     = vx_r;
    vy_nxt     = vy_r;
    vz_nxt     = vz_r;
    vw_nxt     = vw_r;
    usable_nxt = usable_r;
    for (int i = 0; i < 3; i++) begin
      px_nxt[i]  = px_r[i];
      py_nxt[i]  = py_r[i];
      pd_nxt[i]  = pd_r[i];
      t_nxt[i]   = t_r[i];
      wgt_nxt[i] = wgt_r[i];
    end
    bx0_nxt    = bx0_r;
    bx1_nxt    = bx1_r;
    by0_nxt    = by0_r;
    by1_nxt    = by1_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    active_nxt = active_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    dbx_nxt    = dbx_r;
    dby_nxt    = dby_r;
    dcx_nxt    = dcx_r;
    dcy_nxt    = dcy_r;
    qx_nxt     = qx_r;
    qy_nxt     = qy_r;
    prod_nxt   = prod_r;
    sum_nxt    = sum_r;
    nb_nxt     = nb_r;
    nc_nxt     = nc_r;
    area_nxt   = area_r;
    na_nxt     = na_r;
    f_nxt      = f_r;
    o_strobe_nxt = 1'b0;
    o_kind_nxt   = o_kind_r;
    o_x_nxt      = o_x_r;
    o_y_nxt      = o_y_r;
    o_d_nxt      = o_d_r;
    o_wa_nxt     = o_wa_r;
    o_wb_nxt     = o_wb_r;
    o_wc_nxt     = o_wc_r;
    div_req      = '{start: 1'b0, num: '0, den: '0};
    ram_we       = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  fw_nxt = cfg_wdata;
        REG_FRAME_HEIGHT: fh_nxt = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (start && !busy) begin
          o_x_nxt  = '0;
          o_y_nxt  = '0;
          o_d_nxt  = '0;
          o_wa_nxt = '0;
          o_wb_nxt = '0;
          o_wc_nxt = '0;
          if (in_command == CMD_LOAD) begin
            slot_nxt = in_vertex_slot;
            vx_nxt   = in_vert_x;
            vy_nxt   = in_vert_y;
            vz_nxt   = in_vert_z;
            vw_nxt   = in_vert_w;
            k_nxt    = 3'd0;
            if (in_vertex_slot == SLOT_NONE) begin
              o_strobe_nxt = 1'b1;
              o_kind_nxt   = K_LOADED;
            end else if (in_vert_w == '0) begin
              for (int i = 0; i < 3; i++) t_nxt[i] = '0;
              state_nxt = S_VSTORE;
            end else begin
              state_nxt = S_VDIV;
            end
          end else if (!active_r) begin
            o_strobe_nxt = 1'b1;
            o_kind_nxt   = K_DONE;
          end else begin
            x_nxt = cur_x_r;
            y_nxt = cur_y_r;
            if (cur_y_r < by1_r) begin
              cur_y_nxt = cur_y_r + YW'(1);
            end else if (cur_x_r < bx1_r) begin
              cur_x_nxt = cur_x_r + XW'(1);
              cur_y_nxt = by0_r;
            end else begin
              active_nxt = 1'b0;
            end
            state_nxt = S_PREP;
          end
        end
      end
      S_VDIV: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NW'({vmag, 9'b0}) + DIV_NW'(wmag);
        div_req.den   = DIV_DW'({wmag, 1'b0});
        state_nxt     = S_VWAIT;
      end
      S_VWAIT: begin
        if (div_rsp.done) begin
          t_nxt[k_r[1:0]] = vres;
          k_nxt = k_r + 3'd1;
          state_nxt = (k_r == 3'd2) ? S_VSTORE : S_VDIV;
        end
      end
      S_VSTORE: begin
        px_nxt[slot_r]     = t_r[0];
        py_nxt[slot_r]     = t_r[1];
        pd_nxt[slot_r]     = t_r[2];
        usable_nxt[slot_r] = (vw_r != '0);
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        bx0_nxt    = x0full[XW-1:0];
        by0_nxt    = y0full[YW-1:0];
        bx1_nxt    = sx1;
        by1_nxt    = sy1;
        cur_x_nxt  = x0full[XW-1:0];
        cur_y_nxt  = y0full[YW-1:0];
        active_nxt = box_ok;
        o_strobe_nxt = 1'b1;
        o_kind_nxt   = K_LOADED;
        state_nxt    = S_IDLE;
      end
      S_PREP: begin
        dbx_nxt = MUL_W'(px_r[1]) - MUL_W'(px_r[0]);
        dby_nxt = MUL_W'(py_r[1]) - MUL_W'(py_r[0]);
        dcx_nxt = MUL_W'(px_r[2]) - MUL_W'(px_r[0]);
        dcy_nxt = MUL_W'(py_r[2]) - MUL_W'(py_r[0]);
        qx_nxt  = MUL_W'(px_r[0]) - $signed(MUL_W'({x_r, 8'b0}));
        qy_nxt  = MUL_W'(py_r[0]) - $signed(MUL_W'({y_r, 8'b0}));
        k_nxt   = 3'd0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (k_r < 3'd6) prod_nxt = mul_p;
        if (k_r != 3'd0) begin
          case (km1)
            3'd0:    nb_nxt   = EDGE_W'(prod_r);
            3'd1:    nb_nxt   = nb_r - EDGE_W'(prod_r);
            3'd2:    nc_nxt   = EDGE_W'(prod_r);
            3'd3:    nc_nxt   = nc_r - EDGE_W'(prod_r);
            3'd4:    area_nxt = EDGE_W'(prod_r);
            default: area_nxt = area_r - EDGE_W'(prod_r);
          endcase
        end
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd6) state_nxt = S_EDGE;
      end
      S_EDGE: begin
        na_nxt = na_c;
        k_nxt  = 3'd0;
        if (reject) begin
          o_strobe_nxt = 1'b1;
          o_kind_nxt   = K_REJECTED;
          o_x_nxt      = x_r;
          o_y_nxt      = y_r;
          o_d_nxt      = '0;
          o_wa_nxt     = '0;
          o_wb_nxt     = '0;
          o_wc_nxt     = '0;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_WDIV;
        end
      end
      S_WDIV: begin
        div_req.start = 1'b1;
        div_req.num   = {nmag, 15'b0} + DIV_NW'(ua);
        div_req.den   = {ua, 1'b0};
        state_nxt     = S_WWAIT;
      end
      S_WWAIT: begin
        if (div_rsp.done) begin
          wgt_nxt[k_r[1:0]] = div_rsp.quot[WGT_W-1:0];
          k_nxt = (k_r == 3'd2) ? 3'd0 : k_r + 3'd1;
          state_nxt = (k_r == 3'd2) ? S_DMUL : S_WDIV;
        end
      end
      S_DMUL: begin
        if (k_r < 3'd3) prod_nxt = mul_p;
        case (k_r)
          3'd0:    sum_nxt = '0;
          default: sum_nxt = sum_r + prod_r;
        endcase
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd3) state_nxt = S_DFIN;
      end
      S_DFIN: begin
        if (sum_r < 0) f_nxt = '0;
        else if (rnd_hi > (PROD_W-22)'(DLIM)) f_nxt = DEPTH_W'(DLIM);
        else f_nxt = rnd_hi[DEPTH_W-1:0];
        state_nxt = S_DCMP;
      end
      S_DCMP: begin
        ram_we       = (ram_q <= f_r);
        o_strobe_nxt = 1'b1;
        o_kind_nxt   = (ram_q <= f_r) ? K_WRITTEN : K_REJECTED;
        o_x_nxt      = x_r;
        o_y_nxt      = y_r;
        o_d_nxt      = f_r;
        o_wa_nxt     = wgt_r[0];
        o_wb_nxt     = wgt_r[1];
        o_wc_nxt     = wgt_r[2];
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      k_r        <= '0;
      fw_r       <= CFG_W'(512);
      fh_r       <= CFG_W'(512);
      usable_r   <= '0;
      bx0_r      <= '0;
      bx1_r      <= '0;
      by0_r      <= '0;
      by1_r      <= '0;
      cur_x_r    <= '0;
      cur_y_r    <= '0;
      active_r   <= 1'b0;
      o_strobe_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        px_r[i] <= '0;
        py_r[i] <= '0;
        pd_r[i] <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      k_r        <= k_nxt;
      fw_r       <= fw_nxt;
      fh_r       <= fh_nxt;
      usable_r   <= usable_nxt;
      bx0_r      <= bx0_nxt;
      bx1_r      <= bx1_nxt;
      by0_r      <= by0_nxt;
      by1_r      <= by1_nxt;
      cur_x_r    <= cur_x_nxt;
      cur_y_r    <= cur_y_nxt;
      active_r   <= active_nxt;
      o_strobe_r <= o_strobe_nxt;
      for (int i = 0; i < 3; i++) begin
        px_r[i] <= px_nxt[i];
        py_r[i] <= py_nxt[i];
        pd_r[i] <= pd_nxt[i];
      end
    end
    slot_r <= slot_nxt;
    vx_r   <= vx_nxt;
    vy_r   <= vy_nxt;
    vz_r   <= vz_nxt;
    vw_r   <= vw_nxt;
    for (int i = 0; i < 3; i++) begin
      t_r[i]   <= t_nxt[i];
      wgt_r[i] <= wgt_nxt[i];
    end
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    dbx_r    <= dbx_nxt;
    dby_r    <= dby_nxt;
    dcx_r    <= dcx_nxt;
    dcy_r    <= dcy_nxt;
    qx_r     <= qx_nxt;
    qy_r     <= qy_nxt;
    prod_r   <= prod_nxt;
    sum_r    <= sum_nxt;
    nb_r     <= nb_nxt;
    nc_r     <= nc_nxt;
    area_r   <= area_nxt;
    na_r     <= na_nxt;
    f_r      <= f_nxt;
    o_kind_r <= o_kind_nxt;
    o_x_r    <= o_x_nxt;
    o_y_r    <= o_y_nxt;
    o_d_r    <= o_d_nxt;
    o_wa_r   <= o_wa_nxt;
    o_wb_r   <= o_wb_nxt;
    o_wc_r   <= o_wc_nxt;
  end

  assign out_strobe         = o_strobe_r;
  assign out_result_kind    = o_kind_r;
  assign out_pixel_x        = o_x_r;
  assign out_pixel_y        = o_y_r;
  assign out_frag_depth_out = o_d_r;
  assign out_weight_a       = o_wa_r;
  assign out_weight_b       = o_wb_r;
  assign out_weight_c       = o_wc_r;

  a_no_beat_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ram_clearing |-> !out_strobe)
    else $error("result beat during depth store clear");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low after command accepted");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back to back result beats");

  a_done_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result_kind == K_DONE) |->
      (out_pixel_x == '0 && out_pixel_y == '0 && out_frag_depth_out == '0 &&
       out_weight_a == '0 && out_weight_b == '0 && out_weight_c == '0))
    else $error("walk finished beat carries pixel data");

endmodule

[tb/sv/zbuffered_triangle_rasterizer_unit_test.sv]
// Self-checking test of the z-buffered triangle rasterizer: corner loads, pixel walks, depth test.
// Depends on zbr_pkg and zbuffered_triangle_rasterizer_unit; predicts every beat internally.
module zbuffered_triangle_rasterizer_unit_test;
  import zbr_pkg::*;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [XW-1:0]      px;
    logic [YW-1:0]      py;
    logic [DEPTH_W-1:0] depth;
    logic [WGT_W-1:0]   wa, wb, wc;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_command = CMD_LOAD;
  logic [1:0] in_vertex_slot = 2'd0;
  logic signed [23:0] in_vert_x = '0, in_vert_y = '0, in_vert_z = '0, in_vert_w = '0;
  logic out_strobe;
  logic [KIND_W-1:0] out_result_kind;
  logic [XW-1:0] out_pixel_x;
  logic [YW-1:0] out_pixel_y;
  logic [DEPTH_W-1:0] out_frag_depth_out;
  logic [WGT_W-1:0] out_weight_a, out_weight_b, out_weight_c;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;

  zbuffered_triangle_rasterizer_unit dut (.*);

  always #6 clk = ~clk;

  // predictor state
  longint crn_x[3], crn_y[3], crn_d[3];
  bit crn_ok[3];
  longint fr_w = 512, fr_h = 512;
  longint bx0, bx1, by0, by1, wx, wy;
  bit walking;
  byte unsigned zstore[int];
  beat_t pending_beats[$];
  int mismatches = 0;
  int sent_items = 0;
  bit gaps_on = 1'b1;

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint div_round_q8(longint num, longint den);
    longint q;
    q = (2 * absl(num) + absl(den)) / (2 * absl(den));
    if (q > 4194303) q = 4194303;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic longint dim_clamp(longint v, longint mx);
    return v < 1 ? 1 : (v > mx ? mx : v);
  endfunction

  function automatic void rebuild_box();
    longint mnx, mny, mxx, mxy, lx, ly;
    bit ok;
    mnx = 64'sh7fffffffffffffff; mny = mnx; mxx = 0; mxy = 0; ok = 1;
    lx = (dim_clamp(fr_w, MAX_WIDTH) - 1) * 256;
    ly = (dim_clamp(fr_h, MAX_HEIGHT) - 1) * 256;
    for (int i = 0; i < 3; i++) begin
      if (!crn_ok[i]) ok = 0;
      if (crn_x[i] < mnx) mnx = crn_x[i];
      if (crn_y[i] < mny) mny = crn_y[i];
      if (crn_x[i] > mxx) mxx = crn_x[i];
      if (crn_y[i] > mxy) mxy = crn_y[i];
    end
    if (mnx < 0) mnx = 0;
    if (mny < 0) mny = 0;
    if (mxx > lx) mxx = lx;
    if (mxy > ly) mxy = ly;
    bx0 = mnx >>> 8; by0 = mny >>> 8; bx1 = mxx >>> 8; by1 = mxy >>> 8;
    wx = bx0; wy = by0;
    walking = ok && bx0 <= bx1 && by0 <= by1;
  endfunction

  function automatic beat_t predict_raster(logic cmd, logic [1:0] slot, longint vx, longint vy,
                                           longint vz, longint vw);
    beat_t r;
    longint ax, ay, ex, ey, fx, fy, qx, qy, nb, nc, na, ar, ua, wa, wb, wc, sum, f;
    int x, y;
    r = '{default: '0};
    if (cmd == CMD_LOAD) begin
      r.kind = K_LOADED;
      if (slot != SLOT_NONE) begin
        crn_ok[slot] = vw != 0;
        if (vw != 0) begin
          crn_x[slot] = div_round_q8(vx * 256, vw);
          crn_y[slot] = div_round_q8(vy * 256, vw);
          crn_d[slot] = div_round_q8(vz * 256, vw);
        end else begin
          crn_x[slot] = 0; crn_y[slot] = 0; crn_d[slot] = 0;
        end
        rebuild_box();
      end
      return r;
    end
    if (!walking) begin
      r.kind = K_DONE;
      return r;
    end
    x = int'(wx); y = int'(wy);
    r.kind = K_REJECTED; r.px = XW'(x); r.py = YW'(y);
    if (wy < by1) wy++;
    else if (wx < bx1) begin
      wx++; wy = by0;
    end else walking = 0;
    ax = crn_x[0]; ay = crn_y[0];
    ex = crn_x[1] - ax; ey = crn_y[1] - ay;
    fx = crn_x[2] - ax; fy = crn_y[2] - ay;
    qx = ax - longint'(x) * 256; qy = ay - longint'(y) * 256;
    nb = fx * qy - qx * fy;
    nc = qx * ey - ex * qy;
    ar = ex * fy - fx * ey;
    na = ar - nb - nc;
    ua = absl(ar);
    if (ua < AREA_MIN) return r;
    if (ar > 0 ? !(na >= 0 && nb >= 0 && nc >= 0) : !(na <= 0 && nb <= 0 && nc <= 0))
      return r;
    wa = (absl(na) * 32768 + ua) / (2 * ua);
    wb = (absl(nb) * 32768 + ua) / (2 * ua);
    wc = (absl(nc) * 32768 + ua) / (2 * ua);
    sum = wa * crn_d[0] + wb * crn_d[1] + wc * crn_d[2];
    f = sum < 0 ? 0 : (sum + (1 << 21)) >>> 22;
    if (f > DLIM) f = DLIM;
    r.depth = DEPTH_W'(f); r.wa = WGT_W'(wa); r.wb = WGT_W'(wb); r.wc = WGT_W'(wc);
    if (!zstore.exists(y * MAX_WIDTH + x)) zstore[y * MAX_WIDTH + x] = 8'd0;
    if (zstore[y * MAX_WIDTH + x] <= f) begin
      zstore[y * MAX_WIDTH + x] = 8'(f);
      r.kind = K_WRITTEN;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  always @(posedge clk) begin
    beat_t e;
    if (rst_n && out_strobe) begin
      if (pending_beats.size() == 0) report_mismatch("unexpected beat", out_result_kind, -1);
      else begin
        e = pending_beats.pop_front();
        if (out_result_kind !== e.kind) report_mismatch("kind", out_result_kind, e.kind);
        if (out_pixel_x !== e.px) report_mismatch("pixel_x", out_pixel_x, e.px);
        if (out_pixel_y !== e.py) report_mismatch("pixel_y", out_pixel_y, e.py);
        if (out_frag_depth_out !== e.depth) report_mismatch("depth", out_frag_depth_out, e.depth);
        if (out_weight_a !== e.wa) report_mismatch("weight_a", out_weight_a, e.wa);
        if (out_weight_b !== e.wb) report_mismatch("weight_b", out_weight_b, e.wb);
        if (out_weight_c !== e.wc) report_mismatch("weight_c", out_weight_c, e.wc);
      end
    end
  end

  // start stays high on return; the next send_command or drain_results replaces or drops it
  task automatic send_command(logic cmd, logic [1:0] slot, logic signed [23:0] vx,
                              logic signed [23:0] vy, logic signed [23:0] vz,
                              logic signed [23:0] vw);
    if (gaps_on && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_command <= cmd; in_vertex_slot <= slot;
    in_vert_x <= vx; in_vert_y <= vy; in_vert_z <= vz; in_vert_w <= vw;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_beats.push_back(predict_raster(cmd, slot, vx, vy, vz, vw));
    sent_items++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    drain_results();
    cfg_we <= 1'b1; cfg_index <= REG_FRAME_WIDTH; cfg_wdata <= w;
    @(negedge clk);
    cfg_index <= REG_FRAME_HEIGHT; cfg_wdata <= h;
    @(negedge clk);
    cfg_we <= 1'b0;
    fr_w = w; fr_h = h;
  endtask

  task automatic load_corner(int s, int x, int y, int z, int w);
    send_command(CMD_LOAD, 2'(s), 24'(x), 24'(y), 24'(z), 24'(w));
  endtask

  task automatic step_pixels(int n);
    repeat (n) send_command(CMD_STEP, 2'($urandom), 24'($urandom), 24'($urandom),
                            24'($urandom), 24'($urandom));
  endtask

  task automatic run_walk_to_end(int cap);
    int n = 0;
    while (walking && n < cap) begin
      step_pixels(1); n++;
    end
  endtask

  task automatic test_directed();
    step_pixels(1);
    load_corner(0, 256, 256, 256 * 100, 256);
    load_corner(1, 256 * 6, 256, 256 * 200, 256);
    load_corner(3, 24'sh7fffff, 24'sh800000, 0, 256);
    load_corner(2, 256, 256 * 6, 256 * 300, 256);
    run_walk_to_end(40);
    step_pixels(1);
    load_corner(0, 0, 0, 256 * 50, 256);
    run_walk_to_end(40);
    load_corner(1, 24'sh7fffff, 24'sh800000, 24'sh7fffff, 1);
    load_corner(2, 24'sh800000, 24'sh7fffff, 24'sh800000, 24'sh800000);
    step_pixels(3);
    load_corner(2, 256, 256, 256, 0);
    step_pixels(2);
    load_corner(0, 256 * 2, 256 * 2, 256 * 10, 256);
    load_corner(1, 256 * 3, 256 * 3, 256 * 10, 256);
    load_corner(2, 256 * 4, 256 * 4, 256 * 10, 256);
    step_pixels(3);
  endtask

  task automatic random_triangle(int span, int pixels);
    for (int s = 0; s < 3; s++) begin
      int w = $urandom_range(1, 4) * 128;
      if ($urandom_range(15) == 0) w = -w;
      if ($urandom_range(40) == 0) w = 0;
      load_corner(s, ($urandom_range(span) - 2) * w, ($urandom_range(span) - 2) * w,
                  $urandom_range(300) * w - 20 * w + $urandom_range(255), w);
    end
    for (int i = 0; i < pixels && walking; i++) step_pixels(1);
  endtask

  task automatic test_random_triangles(int items);
    int base = sent_items;
    while (sent_items - base < items) begin
      if ($urandom_range(9) == 0) begin
        send_command(1'($urandom), 2'($urandom), 24'($urandom), 24'($urandom),
                     24'($urandom), 24'($urandom));
      end else begin
        random_triangle($urandom_range(4) == 0 ? 14 : 8, $urandom_range(10, 60));
      end
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    write_frame(10'd1, 10'd1);
    test_random_triangles(60);
    write_frame(10'd7, 10'd5);
    test_random_triangles(250);
    drain_results();
    write_frame(10'd0, 10'd1023);
    test_random_triangles(250);
    write_frame(10'd512, 10'd512);
    test_random_triangles(500);
    gaps_on = 1'b0;
    test_random_triangles(250);
    drain_results();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #80000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
